### hw/rtl/ssit_pkg.sv
// Shared widths, codes, request/response types and a helper function for the
// swept sphere-sphere impact time block. No dependencies.
`default_nettype none
package ssit_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int RAD_W     = 8 + FRAC_BITS;
  localparam int TIME_W    = 32;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int RSUM_W    = RAD_W + 1;
  localparam int MAG_W     = ((2 * COORD_W > 2 * RSUM_W) ? 2 * COORD_W : 2 * RSUM_W) + 8;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int DIV_W     = MAG_W + FRAC_BITS;
  localparam int REM_W     = MAG_W + 2;
  localparam int CNT_W     = $clog2(PROD_W);

  localparam logic [TIME_W-1:0] STEP_RESET = TIME_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_SQRT = 2'd1,
    OP_DIV  = 2'd2
  } ssit_op_e;

  typedef enum logic [2:0] {
    P_VV = 3'd0,
    P_VC = 3'd1,
    P_CC = 3'd2,
    P_RR = 3'd3,
    P_BB = 3'd4,
    P_AC = 3'd5
  } ssit_prod_e;

  typedef struct packed {
    logic              start;
    ssit_op_e          op;
    logic [PROD_W-1:0] opa;
    logic [MAG_W-1:0]  opb;
  } ssit_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] result;
  } ssit_rsp_t;

  function automatic logic [MAG_W-1:0] mag_abs(input logic signed [MAG_W-1:0] v);
    mag_abs = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

endpackage
`default_nettype wire

### hw/rtl/ssit_in_if.sv
// Input channel of the impact time block: valid/ready and one sphere.
// Depends on ssit_pkg.
`default_nettype none
interface ssit_in_if import ssit_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic signed [COORD_W-1:0] vel_x;
  logic signed [COORD_W-1:0] vel_y;
  logic signed [COORD_W-1:0] vel_z;
  logic [RAD_W-1:0]          radius;

  modport source (output valid, kind, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, radius,
                  input ready);
  modport sink (input valid, kind, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, radius,
                output ready);
endinterface
`default_nettype wire

### hw/rtl/ssit_out_if.sv
// Output channel of the impact time block: valid/ready, hit flag and time.
// Depends on ssit_pkg.
`default_nettype none
interface ssit_out_if import ssit_pkg::*;;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [TIME_W-1:0] impact_time;

  modport source (output valid, hit, impact_time, input ready);
  modport sink (input valid, hit, impact_time, output ready);
endinterface
`default_nettype wire

### hw/rtl/ssit_iter.sv
// Shared iterative unit: shift-add multiply, bit-pair floor square root and
// restoring division, one step per cycle. Depends on ssit_pkg.
`default_nettype none
module ssit_iter import ssit_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ssit_req_t req_i,
  output ssit_rsp_t      rsp_o
);

  logic              busy_q;
  ssit_op_e          op_q;
  logic [PROD_W-1:0] acc_q, x_q;
  logic [MAG_W-1:0]  y_q;
  logic [REM_W-1:0]  rem_q;
  logic [CNT_W-1:0]  cnt_q;

  logic             finish;
  logic [REM_W-1:0] sq_rem, sq_trial, dv_rem, dv_sor;
  logic             sq_ge, dv_ge;

  assign sq_rem   = {rem_q[REM_W-3:0], acc_q[PROD_W-1 -: 2]};
  assign sq_trial = {x_q[MAG_W-1:0], 2'b01};
  assign sq_ge    = sq_rem >= sq_trial;
  assign dv_rem   = {rem_q[REM_W-2:0], acc_q[DIV_W-1]};
  assign dv_sor   = {2'b00, y_q};
  assign dv_ge    = dv_rem >= dv_sor;

  assign finish = busy_q && ((op_q == OP_MUL) ? (y_q == '0) : (cnt_q == '0));

  assign rsp_o.done   = finish;
  assign rsp_o.result = (op_q == OP_SQRT) ? x_q : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      op_q   <= OP_MUL;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      op_q   <= req_i.op;
    end else if (finish) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      case (req_i.op)
        OP_MUL: begin
          acc_q <= '0;
          x_q   <= req_i.opa;
          y_q   <= req_i.opb;
        end
        OP_SQRT: begin
          acc_q <= req_i.opa;
          x_q   <= '0;
          cnt_q <= CNT_W'(MAG_W);
        end
        OP_DIV: begin
          acc_q <= req_i.opa;
          y_q   <= req_i.opb;
          cnt_q <= CNT_W'(DIV_W);
        end
        default: begin
          acc_q <= '0;
        end
      endcase
    end else if (busy_q && !finish) begin
      case (op_q)
        OP_MUL: begin
          if (y_q[0]) begin
            acc_q <= acc_q + x_q;
          end
          x_q <= x_q << 1;
          y_q <= y_q >> 1;
        end
        OP_SQRT: begin
          acc_q <= acc_q << 2;
          cnt_q <= cnt_q - 1'b1;
          if (sq_ge) begin
            rem_q <= sq_rem - sq_trial;
            x_q   <= {x_q[PROD_W-2:0], 1'b1};
          end else begin
            rem_q <= sq_rem;
            x_q   <= {x_q[PROD_W-2:0], 1'b0};
          end
        end
        OP_DIV: begin
          cnt_q <= cnt_q - 1'b1;
          acc_q <= {acc_q[PROD_W-2:0], dv_ge};
          rem_q <= dv_ge ? (dv_rem - dv_sor) : dv_rem;
        end
        default: begin
          cnt_q <= '0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/sphere_sphere_impact_time.sv
// Top level of the swept sphere-sphere impact time block: sequencer, held
// sphere, step register and output register. Depends on ssit_pkg,
// ssit_in_if, ssit_out_if and ssit_iter.
//
//   channel  direction  handshake    payload
//   in_i     sink       valid/ready  kind, pos_x..z, vel_x..z, radius
//   out_o    source     valid/ready  hit, impact_time
//   cfg      input      cfg_we_i     cfg_wdata_i (step_time)
//
// A kind 0 transfer loads the held sphere. A kind 1 transfer runs twelve products on the
// shared unit and, unless the discriminant is negative or a is zero, a 72-step square
// root and one or two 88-step divisions. Input is not ready meanwhile.
// Reset clears the sequencer, the held sphere and sets step_time to 1.0.
// A stalled result waits in the output register; the next item is still accepted.
`default_nettype none
module sphere_sphere_impact_time import ssit_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [TIME_W-1:0] cfg_wdata_i,
  ssit_in_if.sink                in_i,
  ssit_out_if.source             out_o
);

  typedef enum logic [8:0] {
    S_IDLE       = 9'b000000001,
    S_MUL_ISSUE  = 9'b000000010,
    S_MUL_WAIT   = 9'b000000100,
    S_CHECK      = 9'b000001000,
    S_SQRT_ISSUE = 9'b000010000,
    S_SQRT_WAIT  = 9'b000100000,
    S_DIV_ISSUE  = 9'b001000000,
    S_DIV_WAIT   = 9'b010000000,
    S_DONE       = 9'b100000000
  } state_e;

  state_e     state_q, state_d;
  ssit_prod_e prod_q, prod_d;
  logic [1:0] axis_q, axis_d;
  logic       try_q, try_d;
  logic       mneg_q, mneg_d;
  logic       nneg_q, nneg_d;

  logic [TIME_W-1:0]  step_q, step_d;
  logic [COORD_W-1:0] hpos_q [3];
  logic [COORD_W-1:0] hpos_d [3];
  logic [COORD_W-1:0] hvel_q [3];
  logic [COORD_W-1:0] hvel_d [3];
  logic [RAD_W-1:0]   hrad_q, hrad_d;

  logic [DIFF_W-1:0]        dc_q [3];
  logic [DIFF_W-1:0]        dc_d [3];
  logic [DIFF_W-1:0]        dv_q [3];
  logic [DIFF_W-1:0]        dv_d [3];
  logic [RSUM_W-1:0]        rsum_q, rsum_d;
  logic signed [MAG_W-1:0]  a_q, a_d, b_q, b_d, c_q, c_d;
  logic signed [PROD_W-1:0] d_q, d_d;
  logic [MAG_W-1:0]         s_q, s_d;
  logic                     res_hit_q, res_hit_d;
  logic [TIME_W-1:0]        res_time_q, res_time_d;

  logic              out_valid_q, out_valid_d;
  logic              out_hit_q, out_hit_d;
  logic [TIME_W-1:0] out_time_q, out_time_d;

  ssit_req_t req;
  ssit_rsp_t rsp;

  logic [COORD_W-1:0]      in_pos [3];
  logic [COORD_W-1:0]      in_vel [3];
  logic                    accept;
  logic signed [MAG_W-1:0] m1, m2, dcv, dvv, num;
  logic                    mneg;
  logic [PROD_W-1:0]       sprod;
  logic [DIV_W-1:0]        quo;
  logic                    in_step;

  ssit_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign in_pos[0] = in_i.pos_x;
  assign in_pos[1] = in_i.pos_y;
  assign in_pos[2] = in_i.pos_z;
  assign in_vel[0] = in_i.vel_x;
  assign in_vel[1] = in_i.vel_y;
  assign in_vel[2] = in_i.vel_z;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  assign out_o.valid       = out_valid_q;
  assign out_o.hit         = out_hit_q;
  assign out_o.impact_time = out_time_q;

  assign dcv = MAG_W'($signed(dc_q[axis_q]));
  assign dvv = MAG_W'($signed(dv_q[axis_q]));

  always_comb begin
    m1   = '0;
    m2   = '0;
    mneg = 1'b0;
    case (prod_q)
      P_VV: begin
        m1 = dvv;
        m2 = dvv;
      end
      P_VC: begin
        m1 = dvv;
        m2 = dcv;
      end
      P_CC: begin
        m1 = dcv;
        m2 = dcv;
      end
      P_RR: begin
        m1 = $signed(MAG_W'(rsum_q));
        m2 = $signed(MAG_W'(rsum_q));
      end
      P_BB: begin
        m1 = b_q;
        m2 = b_q;
      end
      P_AC: begin
        m1 = a_q;
        m2 = c_q;
      end
      default: begin
        m1 = '0;
      end
    endcase
    mneg = m1[MAG_W-1] ^ m2[MAG_W-1];
    if (prod_q == P_RR || prod_q == P_AC) begin
      mneg = ~mneg;
    end
  end

  assign sprod   = mneg_q ? (PROD_W'(0) - rsp.result) : rsp.result;
  assign num     = try_q ? ($signed(s_q) - b_q) : (-b_q - $signed(s_q));
  assign quo     = rsp.result[DIV_W-1:0];
  assign in_step = !nneg_q && (quo != '0) && (quo < DIV_W'(step_q));

  always_comb begin
    state_d     = state_q;
    prod_d      = prod_q;
    axis_d      = axis_q;
    try_d       = try_q;
    mneg_d      = mneg_q;
    nneg_d      = nneg_q;
    step_d      = step_q;
    hpos_d      = hpos_q;
    hvel_d      = hvel_q;
    hrad_d      = hrad_q;
    dc_d        = dc_q;
    dv_d        = dv_q;
    rsum_d      = rsum_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    d_d         = d_q;
    s_d         = s_q;
    res_hit_d   = res_hit_q;
    res_time_d  = res_time_q;
    out_valid_d = out_valid_q;
    out_hit_d   = out_hit_q;
    out_time_d  = out_time_q;
    req         = '0;

    if (cfg_we_i) begin
      step_d = cfg_wdata_i;
    end
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!in_i.kind) begin
            hpos_d = in_pos;
            hvel_d = in_vel;
            hrad_d = in_i.radius;
          end else begin
            for (int k = 0; k < 3; k++) begin
              dc_d[k] = {hpos_q[k][COORD_W-1], hpos_q[k]} - {in_pos[k][COORD_W-1], in_pos[k]};
              dv_d[k] = {hvel_q[k][COORD_W-1], hvel_q[k]} - {in_vel[k][COORD_W-1], in_vel[k]};
            end
            rsum_d  = {1'b0, hrad_q} + {1'b0, in_i.radius};
            a_d     = '0;
            b_d     = '0;
            c_d     = '0;
            d_d     = '0;
            axis_d  = '0;
            prod_d  = P_VV;
            state_d = S_MUL_ISSUE;
          end
        end
      end
      S_MUL_ISSUE: begin
        req.start = 1'b1;
        req.op    = OP_MUL;
        req.opa   = PROD_W'(mag_abs(m1));
        req.opb   = mag_abs(m2);
        mneg_d    = mneg;
        state_d   = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (rsp.done) begin
          state_d = S_MUL_ISSUE;
          case (prod_q)
            P_VV: begin
              a_d    = a_q + $signed(sprod[MAG_W-1:0]);
              prod_d = P_VC;
            end
            P_VC: begin
              b_d    = b_q + $signed(sprod[MAG_W-1:0]);
              prod_d = P_CC;
            end
            P_CC: begin
              c_d = c_q + $signed(sprod[MAG_W-1:0]);
              if (axis_q == 2'd2) begin
                prod_d = P_RR;
              end else begin
                axis_d = axis_q + 1'b1;
                prod_d = P_VV;
              end
            end
            P_RR: begin
              c_d    = c_q + $signed(sprod[MAG_W-1:0]);
              prod_d = P_BB;
            end
            P_BB: begin
              d_d    = d_q + $signed(sprod);
              prod_d = P_AC;
            end
            P_AC: begin
              d_d     = d_q + $signed(sprod);
              state_d = S_CHECK;
            end
            default: begin
              state_d = S_CHECK;
            end
          endcase
        end
      end
      S_CHECK: begin
        if (d_q[PROD_W-1] || a_q == '0) begin
          res_hit_d  = 1'b0;
          res_time_d = '0;
          state_d    = S_DONE;
        end else begin
          state_d = S_SQRT_ISSUE;
        end
      end
      S_SQRT_ISSUE: begin
        req.start = 1'b1;
        req.op    = OP_SQRT;
        req.opa   = d_q;
        state_d   = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (rsp.done) begin
          s_d     = rsp.result[MAG_W-1:0];
          try_d   = 1'b0;
          state_d = S_DIV_ISSUE;
        end
      end
      S_DIV_ISSUE: begin
        req.start = 1'b1;
        req.op    = OP_DIV;
        req.opa   = PROD_W'({mag_abs(num), {FRAC_BITS{1'b0}}});
        req.opb   = a_q;
        nneg_d    = num[MAG_W-1];
        state_d   = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (rsp.done) begin
          if (in_step) begin
            res_hit_d  = 1'b1;
            res_time_d = quo[TIME_W-1:0];
            state_d    = S_DONE;
          end else if (!try_q) begin
            try_d   = 1'b1;
            state_d = S_DIV_ISSUE;
          end else begin
            res_hit_d  = 1'b0;
            res_time_d = '0;
            state_d    = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_hit_d   = res_hit_q;
          out_time_d  = res_time_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= STEP_RESET;
      hrad_q      <= '0;
      for (int k = 0; k < 3; k++) begin
        hpos_q[k] <= '0;
        hvel_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      hrad_q      <= hrad_d;
      hpos_q      <= hpos_d;
      hvel_q      <= hvel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    axis_q     <= axis_d;
    try_q      <= try_d;
    mneg_q     <= mneg_d;
    nneg_q     <= nneg_d;
    dc_q       <= dc_d;
    dv_q       <= dv_d;
    rsum_q     <= rsum_d;
    a_q        <= a_d;
    b_q        <= b_d;
    c_q        <= c_d;
    d_q        <= d_d;
    s_q        <= s_d;
    res_hit_q  <= res_hit_d;
    res_time_q <= res_time_d;
    out_hit_q  <= out_hit_d;
    out_time_q <= out_time_d;
  end

endmodule
`default_nettype wire
